// ===== rtl/kmm_pkg.sv =====
// shared types, constants and helpers for the canonical k-mer minimizer stream
package kmm_pkg;

    localparam int KMER_MAX_DEF   = 32;
    localparam int WINDOW_MAX_DEF = 64;

    localparam int CHAR_W  = 8;
    localparam int KLEN_W  = 6;
    localparam int WSIZE_W = 7;
    localparam int VALUE_W = 64;
    localparam int POS_W   = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [KLEN_W-1:0]  KLEN_RESET  = 6'd15;
    localparam logic [WSIZE_W-1:0] WSIZE_RESET = 7'd10;
    localparam logic [POS_W-1:0]   POS_SAT     = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KMER_LENGTH = 2'd0,
        REG_WINDOW_SIZE = 2'd1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVICT_RD,
        ST_EVICT_CHK,
        ST_BACK_RD,
        ST_BACK_CHK,
        ST_PUSH,
        ST_FRONT_RD,
        ST_FRONT_CHK
    } state_t;

    typedef struct packed {
        logic                strand;
        logic [POS_W-1:0]    position;
        logic [VALUE_W-1:0]  value;
    } cand_t;

    localparam int CAND_W = $bits(cand_t);

    typedef struct packed {
        logic       valid;
        logic [1:0] code;
    } base_code_t;

    function automatic base_code_t base_code(input logic [CHAR_W-1:0] c);
        base_code_t r;
        r.valid = 1'b1;
        r.code  = 2'd0;
        case (c)
            8'h41, 8'h61: r.code = 2'd0;
            8'h43, 8'h63: r.code = 2'd1;
            8'h47, 8'h67: r.code = 2'd2;
            8'h54, 8'h74: r.code = 2'd3;
            default:      r.valid = 1'b0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/kmm_base_if.sv =====
// input channel carrying one base character per transaction
interface kmm_base_if;
    logic                        valid;
    logic                        ready;
    logic [kmm_pkg::CHAR_W-1:0]  base_char;
    logic                        sequence_start;

    modport source (output valid, output base_char, output sequence_start, input ready);
    modport sink   (input valid, input base_char, input sequence_start, output ready);
endinterface

// ===== rtl/kmm_result_if.sv =====
// output channel carrying one minimizer per transaction
interface kmm_result_if;
    logic                         valid;
    logic                         ready;
    logic [kmm_pkg::VALUE_W-1:0]  minimizer_value;
    logic [kmm_pkg::POS_W-1:0]    minimizer_position;
    logic                         reverse_strand;

    modport source (output valid, output minimizer_value, output minimizer_position,
                    output reverse_strand, input ready);
    modport sink   (input valid, input minimizer_value, input minimizer_position,
                    input reverse_strand, output ready);
endinterface

// ===== rtl/kmm_cfg_if.sv =====
// configuration write channel
interface kmm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [kmm_pkg::CFG_IDX_W-1:0]   index;
    logic [kmm_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/canonical_kmer_minimizer_stream.sv =====
// top level: rolling canonical k-mers and a ram-held monotonic window of candidates
//
//  channel   | dir | payload                                              | handshake
//  base_ch   | in  | base_char[7:0], sequence_start                       | valid/ready
//  result_ch | out | minimizer_value[63:0], minimizer_position[31:0], rev | valid/ready
//  cfg_ch    | in  | index[1:0] (0 kmer_length, 1 window_size), data[6:0] | valid/ready
//
// a base steps through evict read/check pairs, back read/check pairs, a push and a front read/check;
// the candidate ram (one read port, registered read data) is read once per check
// reset clears control state and loads kmer_length 15, window_size 10
// configuration is taken only between bases and wins over a base in the same cycle
// a result waits in an output register; a stall there only holds the final step
module canonical_kmer_minimizer_stream #(
    parameter int WINDOW_MAX = kmm_pkg::WINDOW_MAX_DEF,
    parameter int KMER_MAX   = kmm_pkg::KMER_MAX_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    kmm_base_if.sink     base_ch,
    kmm_result_if.source result_ch,
    kmm_cfg_if.sink      cfg_ch
);
    localparam int AW  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW  = $clog2(WINDOW_MAX + 1);
    localparam int SW  = AW + 2;
    localparam int WW  = (CW > kmm_pkg::WSIZE_W) ? CW : kmm_pkg::WSIZE_W;
    localparam logic [SW-1:0] MAX_S = SW'(WINDOW_MAX);
    localparam logic [CW-1:0] MAX_C = CW'(WINDOW_MAX);
    localparam logic [WW-1:0] MAX_W = WW'(WINDOW_MAX);
    localparam logic [kmm_pkg::KLEN_W-1:0] KMAX = kmm_pkg::KLEN_W'(KMER_MAX);

    localparam int VW = kmm_pkg::VALUE_W;
    localparam int PW = kmm_pkg::POS_W;

    kmm_pkg::state_t state_reg, state_next;

    logic [kmm_pkg::KLEN_W-1:0]  klen_reg;
    logic [kmm_pkg::WSIZE_W-1:0] wsize_reg;

    logic [VW-1:0] fwd_reg, rev_reg, canon_reg;
    logic [kmm_pkg::KLEN_W-1:0] run_reg;
    logic [PW-1:0] base_index_reg, pos_reg, last_pos_reg;
    logic          rc_reg, add_reg, has_emitted_reg;
    logic [AW-1:0] head_reg;
    logic [CW-1:0] count_reg;

    logic          out_valid_reg;
    logic [VW-1:0] out_value_reg;
    logic [PW-1:0] out_pos_reg;
    logic          out_strand_reg;

    // effective configuration
    logic [kmm_pkg::KLEN_W-1:0] k_eff;
    logic [WW-1:0]              w_eff;

    always_comb
    begin
        if (klen_reg == '0)
            k_eff = kmm_pkg::KLEN_W'(1);
        else if (klen_reg > KMAX)
            k_eff = KMAX;
        else
            k_eff = klen_reg;
        if (wsize_reg == '0)
            w_eff = WW'(1);
        else if (WW'(wsize_reg) > MAX_W)
            w_eff = MAX_W;
        else
            w_eff = WW'(wsize_reg);
    end

    // k-mer update in the accept cycle
    kmm_pkg::base_code_t bc;
    logic [VW-1:0] mask, fwd_base, rev_base, fwd_new, rev_new;
    logic [kmm_pkg::KLEN_W-1:0] run_base, run_new;
    logic [PW-1:0] pos_now;
    logic          take;

    assign take = base_ch.valid && base_ch.ready;

    always_comb
    begin
        bc       = kmm_pkg::base_code(base_ch.base_char);
        mask     = (k_eff == 6'd32) ? '1 : ((VW'(1) << {k_eff, 1'b0}) - VW'(1));
        fwd_base = base_ch.sequence_start ? '0 : fwd_reg;
        rev_base = base_ch.sequence_start ? '0 : rev_reg;
        run_base = base_ch.sequence_start ? '0 : run_reg;
        pos_now  = base_ch.sequence_start ? '0 : base_index_reg;
        fwd_new  = ({fwd_base[VW-3:0], bc.code}) & mask;
        rev_new  = ((VW'(~bc.code) << {k_eff - 6'd1, 1'b0}) | (rev_base >> 2)) & mask;
        run_new  = (run_base < k_eff) ? run_base + 6'd1 : run_base;
    end

    // ram and address arithmetic
    kmm_pkg::cand_t rd_cand, wr_cand;
    logic          ram_wr_en, ram_rd_en;
    logic [AW-1:0] ram_wr_addr, ram_rd_addr;
    logic [SW-1:0] back_sum, tail_sum;
    logic [AW-1:0] back_addr, tail_addr, head_inc;
    logic          evict_hit, pop_hit, win_full, emit_ok, slot_free, full;

    always_comb
    begin
        back_sum  = SW'(head_reg) + SW'(count_reg) - SW'(1);
        back_addr = (back_sum >= MAX_S) ? AW'(back_sum - MAX_S) : AW'(back_sum);
        tail_sum  = SW'(head_reg) + SW'(count_reg);
        tail_addr = (tail_sum >= MAX_S) ? AW'(tail_sum - MAX_S) : AW'(tail_sum);
        head_inc  = (SW'(head_reg) == MAX_S - SW'(1)) ? '0 : head_reg + AW'(1);
        full      = (count_reg >= MAX_C);
        evict_hit = ({1'b0, rd_cand.position} + (PW+1)'(w_eff)) <= {1'b0, pos_reg};
        pop_hit   = rd_cand.value >= canon_reg;
        win_full  = ({1'b0, pos_reg} + (PW+1)'(1)) >= (PW+1)'(w_eff);
        emit_ok   = !has_emitted_reg || (rd_cand.position != last_pos_reg);
        slot_free = !out_valid_reg || result_ch.ready;
    end

    kmm_ram #(
        .WIDTH (kmm_pkg::CAND_W),
        .DEPTH (WINDOW_MAX)
    ) u_cand_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (wr_cand),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (rd_cand)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kmm_pkg::ST_IDLE:
                if (take)
                    state_next = kmm_pkg::ST_EVICT_RD;
            kmm_pkg::ST_EVICT_RD:
                state_next = (count_reg != '0) ? kmm_pkg::ST_EVICT_CHK : kmm_pkg::ST_BACK_RD;
            kmm_pkg::ST_EVICT_CHK:
                state_next = evict_hit ? kmm_pkg::ST_EVICT_RD : kmm_pkg::ST_BACK_RD;
            kmm_pkg::ST_BACK_RD:
                if (!add_reg)
                    state_next = kmm_pkg::ST_FRONT_RD;
                else if (count_reg != '0)
                    state_next = kmm_pkg::ST_BACK_CHK;
                else
                    state_next = kmm_pkg::ST_PUSH;
            kmm_pkg::ST_BACK_CHK:
                state_next = pop_hit ? kmm_pkg::ST_BACK_RD : kmm_pkg::ST_PUSH;
            kmm_pkg::ST_PUSH:
                state_next = kmm_pkg::ST_FRONT_RD;
            kmm_pkg::ST_FRONT_RD:
                state_next = (win_full && count_reg != '0) ? kmm_pkg::ST_FRONT_CHK
                                                           : kmm_pkg::ST_IDLE;
            kmm_pkg::ST_FRONT_CHK:
                if (!emit_ok || slot_free)
                    state_next = kmm_pkg::ST_IDLE;
            default:
                state_next = kmm_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        base_ch.ready = 1'b0;
        ram_rd_en     = 1'b0;
        ram_rd_addr   = head_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = full ? head_reg : tail_addr;
        wr_cand.strand   = rc_reg;
        wr_cand.position = pos_reg;
        wr_cand.value    = canon_reg;
        unique case (state_reg)
            kmm_pkg::ST_IDLE:
                base_ch.ready = !cfg_ch.valid;
            kmm_pkg::ST_EVICT_RD:
                ram_rd_en = (count_reg != '0);
            kmm_pkg::ST_BACK_RD:
            begin
                ram_rd_en   = add_reg && (count_reg != '0);
                ram_rd_addr = back_addr;
            end
            kmm_pkg::ST_PUSH:
                ram_wr_en = 1'b1;
            kmm_pkg::ST_FRONT_RD:
                ram_rd_en = win_full && (count_reg != '0);
            default:
            begin
            end
        endcase
    end

    assign cfg_ch.ready = (state_reg == kmm_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= kmm_pkg::ST_IDLE;
            klen_reg        <= kmm_pkg::KLEN_RESET;
            wsize_reg       <= kmm_pkg::WSIZE_RESET;
            fwd_reg         <= '0;
            rev_reg         <= '0;
            run_reg         <= '0;
            base_index_reg  <= '0;
            last_pos_reg    <= '0;
            has_emitted_reg <= 1'b0;
            head_reg        <= '0;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
            add_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_ch.valid && cfg_ch.ready)
            begin
                if (cfg_ch.index == kmm_pkg::REG_KMER_LENGTH)
                    klen_reg <= cfg_ch.data[kmm_pkg::KLEN_W-1:0];
                else if (cfg_ch.index == kmm_pkg::REG_WINDOW_SIZE)
                    wsize_reg <= cfg_ch.data;
            end

            if (state_reg == kmm_pkg::ST_FRONT_CHK && emit_ok && slot_free)
                out_valid_reg <= 1'b1;
            else if (result_ch.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                kmm_pkg::ST_IDLE:
                    if (take)
                    begin
                        if (base_ch.sequence_start)
                        begin
                            head_reg        <= '0;
                            count_reg       <= '0;
                            last_pos_reg    <= '0;
                            has_emitted_reg <= 1'b0;
                        end
                        if (bc.valid)
                        begin
                            fwd_reg <= fwd_new;
                            rev_reg <= rev_new;
                            run_reg <= run_new;
                        end
                        else
                        begin
                            fwd_reg <= '0;
                            rev_reg <= '0;
                            run_reg <= '0;
                        end
                        add_reg        <= bc.valid && (run_new >= k_eff);
                        base_index_reg <= (pos_now == kmm_pkg::POS_SAT) ? pos_now
                                                                        : pos_now + PW'(1);
                    end
                kmm_pkg::ST_EVICT_CHK:
                    if (evict_hit)
                    begin
                        head_reg  <= head_inc;
                        count_reg <= count_reg - CW'(1);
                    end
                kmm_pkg::ST_BACK_CHK:
                    if (pop_hit)
                        count_reg <= count_reg - CW'(1);
                kmm_pkg::ST_PUSH:
                    if (full)
                        head_reg <= head_inc;
                    else
                        count_reg <= count_reg + CW'(1);
                kmm_pkg::ST_FRONT_CHK:
                    if (emit_ok && slot_free)
                    begin
                        last_pos_reg    <= rd_cand.position;
                        has_emitted_reg <= 1'b1;
                    end
                default:
                begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pos_reg   <= pos_now;
            rc_reg    <= rev_new < fwd_new;
            canon_reg <= (rev_new < fwd_new) ? rev_new : fwd_new;
        end
        if (state_reg == kmm_pkg::ST_FRONT_CHK && emit_ok && slot_free)
        begin
            out_value_reg  <= rd_cand.value;
            out_pos_reg    <= rd_cand.position;
            out_strand_reg <= rd_cand.strand;
        end
    end

    assign result_ch.valid              = out_valid_reg;
    assign result_ch.minimizer_value    = out_value_reg;
    assign result_ch.minimizer_position = out_pos_reg;
    assign result_ch.reverse_strand     = out_strand_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_C)
        else $error("candidate count above capacity");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        SW'(head_reg) < MAX_S)
        else $error("head pointer out of range");

    a_emit_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kmm_pkg::ST_FRONT_CHK && emit_ok && slot_free)
        |=> (has_emitted_reg && result_ch.valid && last_pos_reg == result_ch.minimizer_position))
        else $error("emission not recorded");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kmm_pkg::ST_PUSH) |=> (count_reg != '0))
        else $error("push left list empty");
endmodule

// ===== rtl/kmm_ram.sv =====
// generic single-write, single-read ram with registered read data
module kmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
